FILE: src/rfa_pkg.sv
// Shared types and constants for the register file ALU executor.
// No dependencies; every other file of the block but rfa_ram imports this package.
package rfa_pkg;

  // Instruction codes carried in the command field
  typedef enum logic [2:0] {
    CMD_ADDI = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_AND  = 3'd3,
    CMD_OR   = 3'd4,
    CMD_SLT  = 3'd5,
    CMD_HALT = 3'd6
  } cmd_t;

  localparam int IDX_WIDTH   = 5;
  localparam int IMM_WIDTH   = 16;
  localparam int RES_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;

  typedef logic [IDX_WIDTH-1:0]   idx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Outcome of one instruction, apart from the data result
  typedef struct packed {
    logic exec;      // counted, and written back unless the destination is register zero or out of range
    logic halt_now;  // this beat is the halt that stops the block
  } alu_ctl_t;

endpackage

FILE: src/rfa_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on rfa_pkg for field widths.
interface rfa_instr_if;
  import rfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         command;
  idx_t               dest_reg;
  idx_t               src_a_reg;
  idx_t               src_b_reg;
  logic signed [IMM_WIDTH-1:0] immediate;

  modport source (output valid, command, dest_reg, src_a_reg, src_b_reg, immediate,
                  input ready);
  modport sink   (input valid, command, dest_reg, src_a_reg, src_b_reg, immediate,
                  output ready);
endinterface

interface rfa_result_if;
  import rfa_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [RES_WIDTH-1:0] alu_result;
  logic                        zero_flag;
  count_t                      instr_count;
  logic                        halted;

  modport source (output valid, alu_result, zero_flag, instr_count, halted,
                  input ready);
  modport sink   (input valid, alu_result, zero_flag, instr_count, halted,
                  output ready);
endinterface

FILE: src/rfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port; read returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/rfa_alu.sv
// Combinational ALU for the executor: addi, add, sub, and, or, slt, halt.
// Depends on rfa_pkg for the command codes and the control struct.
module rfa_alu #(
  parameter int DATA_WIDTH = 32
) (
  input  logic [2:0]                         command,
  input  logic                               halt_seen,
  input  logic [DATA_WIDTH-1:0]              a,
  input  logic [DATA_WIDTH-1:0]              b,
  input  logic [rfa_pkg::IMM_WIDTH-1:0]      immediate,
  output logic [DATA_WIDTH-1:0]              res,
  output rfa_pkg::alu_ctl_t                  ctl
);
  import rfa_pkg::*;

  logic signed [DATA_WIDTH-1:0] imm_ext;

  // sign-extend (or truncate) the immediate to the data width
  assign imm_ext = DATA_WIDTH'($signed(immediate));

  // operation select; nothing executes once halted
  always_comb begin
    res          = '0;
    ctl.exec     = 1'b0;
    ctl.halt_now = 1'b0;
    if (!halt_seen) begin
      unique case (cmd_t'(command))
        CMD_ADDI: begin res = a + imm_ext; ctl.exec = 1'b1; end
        CMD_ADD:  begin res = a + b;       ctl.exec = 1'b1; end
        CMD_SUB:  begin res = a - b;       ctl.exec = 1'b1; end
        CMD_AND:  begin res = a & b;       ctl.exec = 1'b1; end
        CMD_OR:   begin res = a | b;       ctl.exec = 1'b1; end
        CMD_SLT:  begin
          res      = DATA_WIDTH'($signed(a) < $signed(b));
          ctl.exec = 1'b1;
        end
        CMD_HALT: ctl.halt_now = 1'b1;
        default:  ;  // unused code: ignored
      endcase
    end
  end

endmodule

FILE: src/register_file_alu_executor.sv
// Top level of the register file ALU executor.
// Depends on rfa_pkg, rfa_if (channels), rfa_ram (register file copies) and rfa_alu.
//
// One decoded instruction beat is accepted per clock while the execute stage is empty or
// advancing. Its result beat passes through the execute stage register and then the output
// register. Throughput is one instruction per cycle, limited only by the result side taking
// beats. The register file lives in two identical one-read, one-write RAMs (one per source
// operand) that are read at accept and written when the instruction leaves the execute
// stage. A write that lands on the same edge as the next instruction's read is forwarded
// from a last-write register. A valid bit per register makes the all-zero reset take
// effect at once, with no clearing pass. After a halt every beat is answered with a zero
// result and the count holds.
module register_file_alu_executor #(
  parameter int REG_COUNT  = 32,
  parameter int DATA_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  rfa_instr_if.sink   instr,
  rfa_result_if.source result
);
  import rfa_pkg::*;

  localparam int AW = $clog2(REG_COUNT);
  localparam logic [IDX_WIDTH+1:0] REG_LIMIT = (IDX_WIDTH+2)'(REG_COUNT);

  typedef logic [AW-1:0]         addr_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // handshake and stage control
  logic in_fire, s1_advance;
  logic s1_valid, out_valid;

  // execute-stage payload
  logic [2:0]           s1_cmd;
  idx_t                 s1_rd, s1_a_idx, s1_b_idx;
  logic [IMM_WIDTH-1:0] s1_imm;

  // architectural state outside the RAMs
  logic [REG_COUNT-1:0] reg_valid;
  count_t               count, count_next;
  logic                 halt_seen;

  // last write, for forwarding into the next read
  logic  fwd_en;
  addr_t fwd_addr;
  data_t fwd_data;

  // RAM and ALU signals
  data_t     ram_a, ram_b, op_a, op_b, res;
  alu_ctl_t  ctl;
  logic      a_ok, b_ok, rd_ok, wr_en;
  addr_t     a_addr, b_addr, wr_addr;

  assign s1_advance  = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || s1_advance;
  assign in_fire     = instr.valid && instr.ready;

  // register file copies, one per source operand
  rfa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_a (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(res),
    .rd_en(in_fire), .rd_addr(addr_t'(instr.src_a_reg)), .rd_data(ram_a)
  );
  rfa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REG_COUNT)) u_ram_b (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(res),
    .rd_en(in_fire), .rd_addr(addr_t'(instr.src_b_reg)), .rd_data(ram_b)
  );

  // operand fetch: out of range reads zero, unwritten reads zero, forward last write
  assign a_ok   = {2'b00, s1_a_idx} < REG_LIMIT;
  assign b_ok   = {2'b00, s1_b_idx} < REG_LIMIT;
  assign rd_ok  = {2'b00, s1_rd} < REG_LIMIT;
  assign a_addr = addr_t'(s1_a_idx);
  assign b_addr = addr_t'(s1_b_idx);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (a_ok) begin
      if (fwd_en && fwd_addr == a_addr) op_a = fwd_data;
      else if (reg_valid[a_addr])       op_a = ram_a;
    end
    if (b_ok) begin
      if (fwd_en && fwd_addr == b_addr) op_b = fwd_data;
      else if (reg_valid[b_addr])       op_b = ram_b;
    end
  end

  rfa_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
    .command(s1_cmd), .halt_seen(halt_seen), .a(op_a), .b(op_b),
    .immediate(s1_imm), .res(res), .ctl(ctl)
  );

  // write back, register zero and out-of-range indexes discarded
  assign wr_addr    = addr_t'(s1_rd);
  assign wr_en      = s1_advance && ctl.exec && rd_ok && (s1_rd != '0);
  assign count_next = ctl.exec ? count + 1'b1 : count;

  // execute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
    if (in_fire) begin
      s1_cmd   <= instr.command;
      s1_rd    <= instr.dest_reg;
      s1_a_idx <= instr.src_a_reg;
      s1_b_idx <= instr.src_b_reg;
      s1_imm   <= instr.immediate;
    end
  end

  // state update as an instruction retires
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
      count     <= '0;
      halt_seen <= 1'b0;
      fwd_en    <= 1'b0;
    end else if (s1_advance) begin
      count <= count_next;
      if (ctl.halt_now) halt_seen <= 1'b1;
      if (wr_en) begin
        reg_valid[wr_addr] <= 1'b1;
        fwd_en             <= 1'b1;
      end
    end
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      result.alu_result  <= RES_WIDTH'(res);
      result.zero_flag   <= ctl.exec && (res == '0);
      result.instr_count <= count_next;
      result.halted      <= halt_seen || ctl.halt_now;
    end
  end

  assign result.valid = out_valid;

  // once halted, the block stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_seen |=> halt_seen)
    else $error("halt flag dropped without reset");

  // a halted block neither counts nor writes
  a_halt_frozen: assert property (@(posedge clk) disable iff (rst)
    halt_seen |-> !wr_en && count_next == count)
    else $error("state changed after halt");

  // register zero is never written
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> s1_rd != '0)
    else $error("write to register zero");

  // an instruction held in execute is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_rd) && $stable(s1_cmd))
    else $error("stalled instruction lost");

endmodule

FILE: dv/rfa_result_checker.sv
// Scoreboard for the register file ALU executor: predicts each result beat and compares it.
// Depends on rfa_pkg and the rfa_instr_if / rfa_result_if channel interfaces.
module rfa_result_checker (
  input  logic  clk,
  input  logic  rst,
  rfa_instr_if  instr_mon,
  rfa_result_if result_mon,
  output int    fail_count,
  output int    pending,
  output int    checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  typedef struct packed {
    logic [RES_WIDTH-1:0] alu_result;
    logic                 zero_flag;
    count_t               instr_count;
    logic                 halted;
  } result_beat_t;

  // Architectural state as the block should hold it
  logic [RES_WIDTH-1:0] reg_image [32];
  count_t               retired;
  logic                 halt_latch;

  result_beat_t results_due[$];

  // Execute one instruction against the register image, return its result beat
  function automatic result_beat_t alu_execute(logic [2:0] cmd, idx_t rd, idx_t ra, idx_t rb,
                                               logic signed [IMM_WIDTH-1:0] imm);
    logic signed [RES_WIDTH-1:0] op_a;
    logic signed [RES_WIDTH-1:0] op_b;
    logic [RES_WIDTH-1:0]        value;
    logic                        exec;
    result_beat_t                beat;
    op_a  = reg_image[ra];
    op_b  = reg_image[rb];
    value = '0;
    exec  = 1'b0;
    if (!halt_latch) begin
      exec = 1'b1;
      case (cmd)
        CMD_ADDI: value = op_a + {{(RES_WIDTH-IMM_WIDTH){imm[IMM_WIDTH-1]}}, imm};
        CMD_ADD:  value = op_a + op_b;
        CMD_SUB:  value = op_a - op_b;
        CMD_AND:  value = op_a & op_b;
        CMD_OR:   value = op_a | op_b;
        CMD_SLT:  value = (op_a < op_b) ? 1 : 0;
        CMD_HALT: begin
          halt_latch = 1'b1;
          exec       = 1'b0;
        end
        default:  exec = 1'b0;
      endcase
    end
    // register zero is hardwired; unused codes and halts leave a zero result
    if (exec) begin
      if (rd != '0) reg_image[rd] = value;
      retired = retired + 1'b1;
    end else begin
      value = '0;
    end
    beat.alu_result  = value;
    beat.zero_flag   = exec && (value == '0);
    beat.instr_count = retired;
    beat.halted      = halt_latch;
    return beat;
  endfunction

  function automatic void check_field(string name, logic [RES_WIDTH-1:0] want,
                                      logic [RES_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%h, got 0x%h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Predict on instruction beats, compare on result beats
  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      foreach (reg_image[i]) reg_image[i] = '0;
      retired    = '0;
      halt_latch = 1'b0;
      results_due.delete();
    end else begin
      if (instr_mon.valid && instr_mon.ready)
        results_due.push_back(alu_execute(instr_mon.command, instr_mon.dest_reg,
                                          instr_mon.src_a_reg, instr_mon.src_b_reg,
                                          instr_mon.immediate));
      if (result_mon.valid && result_mon.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got 0x%h",
                   $time, result_mon.alu_result);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("alu_result", want.alu_result, result_mon.alu_result);
          check_field("zero_flag", RES_WIDTH'(want.zero_flag),
                      RES_WIDTH'(result_mon.zero_flag));
          check_field("instr_count", RES_WIDTH'(want.instr_count),
                      RES_WIDTH'(result_mon.instr_count));
          check_field("halted", RES_WIDTH'(want.halted), RES_WIDTH'(result_mon.halted));
          checked++;
        end
      end
    end
    pending = results_due.size();
  end

endmodule

FILE: dv/register_file_alu_executor_tb.sv
// Top of the register file ALU executor testbench: clock, reset, instruction stimulus, verdict.
// Depends on rfa_pkg, the channel interfaces, the executor RTL and rfa_result_checker.
module register_file_alu_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfa_pkg::*;

  // Command code that the block has no operation for
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  bit   steady;
  int   ready_hold;
  int   sent_by_cmd [8];

  rfa_instr_if  instr_ch ();
  rfa_result_if result_ch ();

  register_file_alu_executor dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  rfa_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .instr_mon  (instr_ch),
    .result_mon (result_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  always @(negedge clk) begin
    if (steady || rst) begin
      result_ch.ready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      result_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) ready_hold = pick_gap();
    end
  end

  // Drive one instruction beat after an optional idle gap; returns once accepted
  task automatic send_instr(logic [2:0] cmd, idx_t rd, idx_t ra, idx_t rb,
                            logic signed [IMM_WIDTH-1:0] imm);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      instr_ch.valid     <= 1'b0;
      instr_ch.command   <= 3'($urandom);
      instr_ch.dest_reg  <= idx_t'($urandom);
      instr_ch.src_a_reg <= idx_t'($urandom);
      instr_ch.src_b_reg <= idx_t'($urandom);
      instr_ch.immediate <= IMM_WIDTH'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    instr_ch.valid     <= 1'b1;
    instr_ch.command   <= cmd;
    instr_ch.dest_reg  <= rd;
    instr_ch.src_a_reg <= ra;
    instr_ch.src_b_reg <= rb;
    instr_ch.immediate <= imm;
    do @(posedge clk); while (!instr_ch.ready);
    sent_by_cmd[cmd]++;
  endtask

  initial begin
    int                          rand_items;
    int                          chain_len;
    int                          post_halt;
    logic [2:0]                  cmd;
    idx_t                        rd;
    idx_t                        ra;
    idx_t                        rb;
    logic signed [IMM_WIDTH-1:0] imm;

    rst                = 1'b1;
    steady             = 1'b0;
    instr_ch.valid     = 1'b0;
    instr_ch.command   = '0;
    instr_ch.dest_reg  = '0;
    instr_ch.src_a_reg = '0;
    instr_ch.src_b_reg = '0;
    instr_ch.immediate = '0;
    result_ch.ready    = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: immediate extremes, register zero, every ALU op but halt, signed compare, unused code
    send_instr(CMD_ADDI, 5'd1, 5'd0, 5'd0, 16'sh7FFF);
    send_instr(CMD_ADDI, 5'd2, 5'd0, 5'd0, -16'sh8000);
    send_instr(CMD_ADDI, 5'd3, 5'd1, 5'd9, -16'sd1);
    send_instr(CMD_ADDI, 5'd0, 5'd1, 5'd0, 16'sd5);
    send_instr(CMD_ADD,  5'd4, 5'd0, 5'd0, 16'sd0);
    send_instr(CMD_ADD,  5'd5, 5'd1, 5'd2, 16'sd0);
    send_instr(CMD_SUB,  5'd6, 5'd0, 5'd2, 16'sd0);
    send_instr(CMD_SUB,  5'd7, 5'd2, 5'd1, 16'sd0);
    send_instr(CMD_SUB,  5'd8, 5'd1, 5'd1, 16'sd0);
    send_instr(CMD_AND,  5'd9, 5'd5, 5'd2, 16'sd0);
    send_instr(CMD_AND,  5'd10, 5'd1, 5'd6, 16'sd0);
    send_instr(CMD_OR,   5'd11, 5'd1, 5'd6, 16'sd0);
    send_instr(CMD_OR,   5'd12, 5'd0, 5'd0, 16'sd0);
    send_instr(CMD_SLT,  5'd13, 5'd2, 5'd1, 16'sd0);
    send_instr(CMD_SLT,  5'd14, 5'd1, 5'd2, 16'sd0);
    send_instr(CMD_SLT,  5'd15, 5'd5, 5'd5, 16'sd0);
    send_instr(CMD_SLT,  5'd16, 5'd0, 5'd5, 16'sd0);
    send_instr(CMD_UNUSED, 5'd17, 5'd1, 5'd2, -16'sd1);
    send_instr(CMD_ADDI, 5'd31, 5'd31, 5'd31, -16'sd1);
    send_instr(CMD_ADD,  5'd31, 5'd31, 5'd31, 16'sd0);
    send_instr(CMD_ADDI, 5'd30, 5'd5, 5'd0, 16'sd1);
    send_instr(CMD_SUB,  5'd29, 5'd2, 5'd6, 16'sd0);

    // Random: doubling chains reach the 32-bit extremes and overflow, the rest is mixed ops
    rand_items = 0;
    while (rand_items < 1000) begin
      if ($urandom_range(0, 49) == 0) steady = ~steady;
      if ($urandom_range(0, 9) < 2) begin
        rd        = idx_t'($urandom_range(1, 31));
        chain_len = ($urandom_range(0, 2) == 0) ? 31 : $urandom_range(1, 33);
        if ($urandom_range(0, 1) == 0) begin
          send_instr(CMD_ADDI, rd, 5'd0, idx_t'($urandom), 16'sd1);
        end else begin
          send_instr(CMD_ADDI, rd, idx_t'($urandom), idx_t'($urandom),
                     IMM_WIDTH'($urandom));
        end
        repeat (chain_len) send_instr(CMD_ADD, rd, rd, rd, IMM_WIDTH'($urandom));
        send_instr(CMD_ADDI, rd, rd, idx_t'($urandom), -16'sd1);
        if ($urandom_range(0, 1) == 0) begin
          send_instr(CMD_SLT, idx_t'($urandom), rd, idx_t'($urandom), IMM_WIDTH'($urandom));
        end else begin
          send_instr(CMD_SLT, idx_t'($urandom), idx_t'($urandom), rd, IMM_WIDTH'($urandom));
        end
        rand_items += chain_len + 3;
      end else begin
        cmd = ($urandom_range(0, 29) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 5));
        rd  = idx_t'($urandom);
        ra  = idx_t'($urandom);
        rb  = ($urandom_range(0, 7) == 0) ? ra : idx_t'($urandom);
        imm = IMM_WIDTH'($urandom);
        send_instr(cmd, rd, ra, rb, imm);
        if (cmd != CMD_UNUSED) rand_items++;
      end
    end

    // Halt, then beats that must all be ignored, including a second halt
    send_instr(CMD_HALT, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
               IMM_WIDTH'($urandom));
    for (post_halt = 0; post_halt < 40; post_halt++) begin
      cmd = (post_halt == 20) ? CMD_HALT : 3'($urandom);
      send_instr(cmd, idx_t'($urandom), idx_t'($urandom), idx_t'($urandom),
                 IMM_WIDTH'($urandom));
    end

    // Drain: every predicted beat back, then an idle wait for strays
    @(negedge clk);
    instr_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Run covered %0d instruction beats (%0d random, 40 after the first halt),",
             sent_by_cmd.sum(), rand_items);
    $display("  %0d result beats checked under random stalls on both channels.", checked);
    $display("Per command: addi %0d add %0d sub %0d and %0d or %0d slt %0d halt %0d unused %0d",
             sent_by_cmd[CMD_ADDI], sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_SUB],
             sent_by_cmd[CMD_AND], sent_by_cmd[CMD_OR], sent_by_cmd[CMD_SLT],
             sent_by_cmd[CMD_HALT], sent_by_cmd[CMD_UNUSED]);
    if (fail_count == 0) begin
      $display("register_file_alu_executor verification clean");
    end else begin
      $display("register_file_alu_executor verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d result beats outstanding", $time, pending);
    $display("register_file_alu_executor verification failed");
    $finish;
  end

endmodule
